// ===== sv/wgm_pkg.sv =====
package wgm_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    localparam int SYM_W      = 8;
    localparam int CODE_W     = 5;
    localparam int OPC_W      = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [OPC_W-1:0] OPC_CLEAR  = 2'd0;
    localparam logic [OPC_W-1:0] OPC_APPEND = 2'd1;
    localparam logic [OPC_W-1:0] OPC_TEXT   = 2'd2;

    typedef logic [CODE_W-1:0] sym_code_t;

    localparam sym_code_t CODE_OTHER = 5'd0;
    localparam sym_code_t CODE_ANY   = 5'd27;
    localparam sym_code_t CODE_STAR  = 5'd28;

    localparam logic [SYM_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_ANY  = 8'h3F;
    localparam logic [SYM_W-1:0] CHAR_UA   = 8'h41;
    localparam logic [SYM_W-1:0] CHAR_UZ   = 8'h5A;
    localparam logic [SYM_W-1:0] CHAR_LA   = 8'h61;
    localparam logic [SYM_W-1:0] CHAR_LZ   = 8'h7A;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_APPEND,
        KIND_TEXT
    } item_kind_t;

    typedef struct packed {
        item_kind_t kind;
        sym_code_t  code;
        logic       last;
    } item_t;

    // letters to 1..26 regardless of case, everything else to 0
    function automatic sym_code_t fold_letter(input logic [SYM_W-1:0] b);
        sym_code_t r;
        r = CODE_OTHER;
        if (b >= CHAR_UA && b <= CHAR_UZ)
        begin
            r = CODE_W'(b - CHAR_UA + 8'd1);
        end
        else if (b >= CHAR_LA && b <= CHAR_LZ)
        begin
            r = CODE_W'(b - CHAR_LA + 8'd1);
        end
        return r;
    endfunction

endpackage

// ===== sv/wildcard_glob_matcher.sv =====
// Glob matcher: '*' matches any run, '?' one character, letters fold case,
// all non-letters compare equal.
// Input stream: s_tuser carries the opcode (clear, append pattern symbol,
// text character), s_tdata the byte, s_tlast the final text character of a
// string. Opcode 3 beats are taken and dropped.
// Output stream: one beat per string, on its last text character, with the
// match bit and the pattern overflow flag.
// Throughput: one input beat per cycle, sustained while no result is held by the receiver;
// the state update of the active-position vector, with its star closure as a single carry
// chain, is combinational in the back end and registered in act_reg.
// Result path: the last text beat is written into the queue and popped by the back end,
// which registers the result onto m_tvalid and m_tdata.
// Reset: empty pattern, position zero active, overflow clear, no pending beat.
// Stall: a held result keeps m_tdata steady; the back end keeps running on
// beats that make no result, and the two-entry queue deasserts s_tready only
// after the back end has been stalled by the receiver.
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] symbol
    input  logic [OPC_W-1:0]      s_tuser,   // [1:0] opcode
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    logic  keep;
    logic  full;
    logic  pop;
    logic  head_valid;
    item_t front_item;
    item_t head_item;

    assign s_tready = !full;

    wgm_front u_front (
        .opcode (s_tuser),
        .symbol (s_tdata),
        .last   (s_tlast),
        .keep   (keep),
        .item   (front_item)
    );

    wgm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid && s_tready && keep),
        .push_item  (front_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    wgm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== sv/wgm_front.sv =====
module wgm_front
    import wgm_pkg::*;
(
    input  logic [OPC_W-1:0] opcode,
    input  logic [SYM_W-1:0] symbol,
    input  logic             last,
    output logic             keep,
    output item_t            item
);

    always_comb
    begin
        keep      = 1'b1;
        item.kind = KIND_TEXT;
        item.code = fold_letter(symbol);
        item.last = last;
        unique case (opcode)
            OPC_CLEAR:
            begin
                item.kind = KIND_CLEAR;
            end
            OPC_APPEND:
            begin
                item.kind = KIND_APPEND;
                if (symbol == CHAR_STAR)
                begin
                    item.code = CODE_STAR;
                end
                else if (symbol == CHAR_ANY)
                begin
                    item.code = CODE_ANY;
                end
            end
            OPC_TEXT:
            begin
                item.kind = KIND_TEXT;
            end
            default:
            begin
                // unused opcode: beat is taken and dropped
                keep = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/wgm_queue.sv =====
module wgm_queue
    import wgm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t      mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/wgm_back.sv =====
module wgm_back
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  item_t                 head_item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int POS_W = PATTERN_MAX + 1;

    typedef logic [POS_W-1:0] pos_vec_t;

    sym_code_t             code_reg [PATTERN_MAX];
    logic [LEN_W-1:0]      len_reg, len_next;
    pos_vec_t              act_reg, act_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                   is_result;
    logic                   app_ok;
    logic                   matched;
    logic [PATTERN_MAX-1:0] hit;
    pos_vec_t               star_cur;
    pos_vec_t               star_app;
    pos_vec_t               text_vec;
    pos_vec_t               restart_cur;
    pos_vec_t               restart_app;

    // star closure as a carry chain: generate = active star, propagate = star
    function automatic pos_vec_t closure(input pos_vec_t act, input pos_vec_t st);
        pos_vec_t a;
        pos_vec_t b;
        pos_vec_t s;
        a = st;
        b = st & act;
        s = a + b;
        return act | (s ^ a ^ b);
    endfunction

    assign is_result = (head_item.kind == KIND_TEXT) && head_item.last;
    assign pop       = head_valid && (!is_result || !out_valid_reg || m_tready);
    assign app_ok    = (len_reg < LEN_W'(PATTERN_MAX));
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        star_cur = '0;
        star_app = '0;
        hit      = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            star_cur[i] = (LEN_W'(i) < len_reg) && (code_reg[i] == CODE_STAR);
            star_app[i] = star_cur[i] ||
                          (app_ok && (LEN_W'(i) == len_reg) && (head_item.code == CODE_STAR));
            hit[i]      = (LEN_W'(i) < len_reg) &&
                          ((code_reg[i] == CODE_ANY) || (code_reg[i] == head_item.code));
        end
        text_vec    = closure((act_reg & star_cur) | {act_reg[PATTERN_MAX-1:0] & hit, 1'b0},
                              star_cur);
        restart_cur = closure(pos_vec_t'(1), star_cur);
        restart_app = closure(pos_vec_t'(1), star_app);
        matched     = text_vec[len_reg];
    end

    always_comb
    begin
        len_next       = len_reg;
        act_next       = act_reg;
        ovf_next       = ovf_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop)
        begin
            unique case (head_item.kind)
                KIND_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    act_next = pos_vec_t'(1);
                end
                KIND_APPEND:
                begin
                    if (app_ok)
                    begin
                        len_next = LEN_W'(len_reg + 1'b1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    act_next = restart_app;
                end
                KIND_TEXT:
                begin
                    if (head_item.last)
                    begin
                        act_next       = restart_cur;
                        out_valid_next = 1'b1;
                        out_data_next  = {{(OUT_DATA_W-2){1'b0}}, ovf_reg, matched};
                    end
                    else
                    begin
                        act_next = text_vec;
                    end
                end
                default:
                begin
                    act_next = act_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            act_reg       <= pos_vec_t'(1);
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            act_reg       <= act_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (pop && (head_item.kind == KIND_APPEND) && app_ok)
        begin
            code_reg[len_reg[IDX_W-1:0]] <= head_item.code;
        end
    end

endmodule

// ===== sv/wgm_checker.sv =====
module wgm_checker
    import wgm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [OPC_W-1:0]      s_tuser,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    // the queue only fills up behind a stalled result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:2] == '0))
        else $error("result padding not zero");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import wgm_pkg::*;

    localparam int PAT_CAP = PATTERN_MAX_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [OPC_W-1:0] OPC_SPARE = 2'd3;

    typedef struct {
        bit matched;
        bit overflow;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OPC_W-1:0]      s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    wildcard_glob_matcher DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] symbol
        .s_tuser  (s_tuser),   // [1:0] opcode
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [0] matched, [1] pattern_overflow, [7:2] zero
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // glob matcher state as predicted
    sym_code_t      glob_pat [PAT_CAP];
    int             glob_len = 0;
    logic [PAT_CAP:0] live_pos = 1;
    bit             ovf_seen = 1'b0;
    verdict_t       pending_verdicts [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int beats_sent = 0;
    int strings_checked = 0;
    int strings_matched = 0;
    int strings_overflowed = 0;
    int err_count = 0;
    int cycle_count = 0;

    function automatic sym_code_t letter_code(input logic [7:0] b);
        logic [7:0] low;
        low = b | 8'h20;
        if (low >= CHAR_LA && low <= CHAR_LZ)
        begin
            return sym_code_t'(low - CHAR_LA + 8'd1);
        end
        return CODE_OTHER;
    endfunction

    function automatic logic [PAT_CAP:0] star_close(input logic [PAT_CAP:0] v);
        for (int i = 0; i < glob_len; i++)
        begin
            if (v[i] && glob_pat[i] == CODE_STAR)
            begin
                v[i+1] = 1'b1;
            end
        end
        return v;
    endfunction

    task automatic restart_text();
        live_pos = '0;
        live_pos[0] = 1'b1;
        live_pos = star_close(live_pos);
    endtask

    task automatic predict_beat(input logic [OPC_W-1:0] opc, input logic [7:0] sym,
                                input logic lst);
        logic [PAT_CAP:0] nxt;
        sym_code_t        c;
        verdict_t         v;
        case (opc)
            OPC_CLEAR:
            begin
                glob_len = 0;
                ovf_seen = 1'b0;
                restart_text();
            end
            OPC_APPEND:
            begin
                if (glob_len < PAT_CAP)
                begin
                    if (sym == CHAR_STAR)
                        glob_pat[glob_len] = CODE_STAR;
                    else if (sym == CHAR_ANY)
                        glob_pat[glob_len] = CODE_ANY;
                    else
                        glob_pat[glob_len] = letter_code(sym);
                    glob_len++;
                end
                else
                begin
                    ovf_seen = 1'b1;
                end
                restart_text();
            end
            OPC_TEXT:
            begin
                c = letter_code(sym);
                nxt = '0;
                for (int i = 0; i < glob_len; i++)
                begin
                    if (live_pos[i])
                    begin
                        if (glob_pat[i] == CODE_STAR)
                            nxt[i] = 1'b1;
                        else if (glob_pat[i] == CODE_ANY || glob_pat[i] == c)
                            nxt[i+1] = 1'b1;
                    end
                end
                live_pos = star_close(nxt);
                if (lst)
                begin
                    v.matched = live_pos[glob_len];
                    v.overflow = ovf_seen;
                    pending_verdicts.push_back(v);
                    restart_text();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_beat(input logic [OPC_W-1:0] opc, input logic [7:0] sym,
                             input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= sym;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        predict_beat(opc, sym, lst);
        if (opc != OPC_SPARE)
        begin
            beats_sent++;
        end
    endtask

    task automatic load_glob(input string p);
        send_beat(OPC_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < p.len(); i++)
        begin
            send_beat(OPC_APPEND, p[i], 1'b0);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(OPC_TEXT, s[i], i == s.len() - 1);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_nonletter();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (letter_code(b) != CODE_OTHER);
        return b;
    endfunction

    function automatic logic [7:0] rand_letter(input sym_code_t k);
        return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(k) - 8'd1;
    endfunction

    function automatic logic [7:0] rand_glob_byte();
        int r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 20)
            return CHAR_STAR;
        if (r < 35)
            return CHAR_ANY;
        if (r < 80)
            return rand_letter(sym_code_t'($urandom_range(1, 26)));
        do
            b = rand_nonletter();
        while (b == CHAR_STAR || b == CHAR_ANY);
        return b;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("MISMATCH string %0d, %s: got %0d, expected %0d",
                 strings_checked, field, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            strings_checked++;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("unexpected beat", int'(m_tdata), -1);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.matched)
                    report_mismatch("matched", int'(m_tdata[0]), int'(want.matched));
                if (m_tdata[1] !== want.overflow)
                    report_mismatch("pattern_overflow", int'(m_tdata[1]),
                                    int'(want.overflow));
                if (m_tdata[7:2] !== 6'd0)
                    report_mismatch("pad", int'(m_tdata[7:2]), 0);
                if (want.matched)
                    strings_matched++;
                if (want.overflow)
                    strings_overflowed++;
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("wildcard_glob_matcher test failed");
            $finish;
        end
    end

    task automatic test_directed_match();
        send_beat(OPC_CLEAR, 8'hFF, 1'b1);
        send_beat(OPC_APPEND, "A", 1'b0);
        send_beat(OPC_APPEND, "*", 1'b0);
        send_beat(OPC_APPEND, "?", 1'b0);
        send_beat(OPC_APPEND, "z", 1'b0);
        send_text("aXyZ");
        send_text("az");
        send_beat(OPC_SPARE, 8'h55, 1'b1);
        wait_drained();
    endtask

    task automatic test_directed_edges();
        // trailing star on an empty remainder
        load_glob("ab*");
        send_text("AB");
        // non-letters all compare equal, including '*' in text
        load_glob("#*#");
        send_beat(OPC_TEXT, 8'h00, 1'b0);
        send_text("@[`{");
        send_beat(OPC_TEXT, 8'hFF, 1'b0);
        send_text("*");
        // empty pattern never matches a string
        load_glob("");
        send_text("x");
        wait_drained();
    endtask

    task automatic test_overflow();
        send_beat(OPC_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < PAT_CAP - 1; i++)
        begin
            send_beat(OPC_APPEND, CHAR_ANY, 1'b0);
        end
        send_beat(OPC_APPEND, CHAR_STAR, 1'b1);
        repeat (3) send_beat(OPC_APPEND, "k", 1'($urandom_range(0, 1)));
        for (int i = 0; i < PAT_CAP - 1; i++)
        begin
            send_beat(OPC_TEXT, "q", i == PAT_CAP - 2);
        end
        send_text("short");
        load_glob("q");
        send_text("Q");
        wait_drained();
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int quota);
        int         stop_at;
        int         n;
        int         pos;
        bit         abort;
        logic [7:0] txt [$];
        stop_at = beats_sent + quota;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_beat(OPC_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                continue;
            end
            if ($urandom_range(0, 4) != 0)
                send_beat(OPC_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            repeat (n)
                send_beat(OPC_APPEND, rand_glob_byte(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 5))
            begin
                txt.delete();
                for (int i = 0; i < glob_len; i++)
                begin
                    case (glob_pat[i])
                        CODE_STAR:  repeat ($urandom_range(0, 3))
                                        txt.push_back(8'($urandom_range(0, 255)));
                        CODE_ANY:   txt.push_back(8'($urandom_range(0, 255)));
                        CODE_OTHER: txt.push_back(rand_nonletter());
                        default:    txt.push_back(rand_letter(glob_pat[i]));
                    endcase
                end
                if (txt.size() > 0 && $urandom_range(0, 2) == 0)
                begin
                    pos = $urandom_range(0, txt.size() - 1);
                    case ($urandom_range(0, 2))
                        0: txt[pos] = 8'($urandom_range(0, 255));
                        1: txt.delete(pos);
                        default: txt.insert(pos, 8'($urandom_range(0, 255)));
                    endcase
                end
                if (txt.size() == 0)
                    txt.push_back(8'($urandom_range(0, 255)));
                abort = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < txt.size(); i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_beat(OPC_SPARE, 8'($urandom_range(0, 255)), 1'b1);
                    send_beat(OPC_TEXT, txt[i], !abort && i == txt.size() - 1);
                end
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_pct = 25;
        sink_stall_pct = 59;
        test_directed_match();
        test_directed_edges();
        test_overflow();
        test_random(25, 59, 170);
        test_random(59, 25, 170);
        test_random(0, 0, 180);
        $display("Sent %0d beats in %0d cycles; %0d strings checked, %0d matched,",
                 beats_sent, cycle_count, strings_checked, strings_matched);
        $display("%0d with pattern overflow; %0d mismatches", strings_overflowed, err_count);
        if (err_count == 0)
        begin
            $display("wildcard_glob_matcher test passed");
        end
        else
        begin
            $display("wildcard_glob_matcher test failed");
        end
        $finish;
    end

endmodule
